### design/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int MaxRows   = 64;
  localparam int MaxCols   = 64;
  localparam int RowW      = 64;
  localparam int RowAw     = $clog2(MaxRows);
  localparam int RowCntW   = 7;
  localparam int RowCntWp1 = RowCntW + 1;
  localparam int IdxW      = 6;
  localparam int CfgDataW  = 7;
  localparam int RowLimit  = (MaxRows < 64) ? MaxRows : 64;

  typedef logic [RowW-1:0]     row_t;
  typedef logic [RowAw-1:0]    row_addr_t;
  typedef logic [RowCntW-1:0]  row_cnt_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  typedef enum logic [0:0] {
    CfgNumRows = 1'b0,
    CfgNumCols = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ModeLoad = 1'b0,
    ModeStep = 1'b1
  } mode_e;

endpackage

### design/lgs_in_if.sv
// ----------------------------------------------------------------------------
// lgs_in_if
// Input channel: one load or step word.
// ----------------------------------------------------------------------------
interface lgs_in_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [5:0]            row_index;
  logic [63:0]           row_cells;

  modport source (output valid, output mode, output row_index, output row_cells,
                  input ready);
  modport sink   (input valid, input mode, input row_index, input row_cells,
                  output ready);
endinterface

### design/lgs_out_if.sv
// ----------------------------------------------------------------------------
// lgs_out_if
// Output channel: one new-generation row word.
// ----------------------------------------------------------------------------
interface lgs_out_if;
  logic                  valid;
  logic                  ready;
  logic [5:0]            out_row_index;
  logic [63:0]           out_row_cells;
  logic                  last_row;

  modport source (output valid, output out_row_index, output out_row_cells,
                  output last_row, input ready);
  modport sink   (input valid, input out_row_index, input out_row_cells,
                  input last_row, output ready);
endinterface

### design/lgs_cfg_if.sv
// ----------------------------------------------------------------------------
// lgs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [6:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/life_generation_step.sv
// ----------------------------------------------------------------------------
// life_generation_step
// Bounded B3/S23 life grid held one row word per entry in a synchronous RAM.
// ----------------------------------------------------------------------------
// A load word writes one row. A step word streams the rows in use through a
// three-row window: the block fetches row 0, primes the window, then gives one
// row word per cycle while the output side takes every word at once and stalls
// while it does not; that rate is bounded by the single read port of the grid
// RAM. New rows are written back in place behind the window. Reset marks every
// row empty through a per-row valid bit, so no clearing pass is needed and the
// block accepts words right after reset.
module life_generation_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  lgs_in_if.sink        in_i,
  lgs_out_if.source     out_o,
  lgs_cfg_if.sink       cfg_i
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StPrime = 3'b010,
    StCalc  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  lgs_pkg::cfg_data_t          num_rows_q, num_cols_q;
  lgs_pkg::row_cnt_t           r_q, r_d;
  lgs_pkg::row_t               above_q, above_d, mid_q, mid_d;
  logic [lgs_pkg::MaxRows-1:0] valid_q, valid_d;
  logic                        rvalid_q;

  logic                        out_valid_q, out_valid_d;
  logic [lgs_pkg::IdxW-1:0]    out_idx_q, out_idx_d;
  lgs_pkg::row_t               out_cells_q, out_cells_d;
  logic                        out_last_q, out_last_d;

  lgs_pkg::row_cnt_t           rows_used;
  lgs_pkg::cfg_data_t          cols_used;
  lgs_pkg::row_t               col_mask;
  lgs_pkg::row_t               rdata, below, new_row;
  logic [lgs_pkg::RowCntWp1-1:0] r_p1, r_p2;
  logic                        in_fire, out_free, has_below, is_last;

  logic                        ram_we, ram_re;
  lgs_pkg::row_addr_t          ram_waddr, ram_raddr;
  lgs_pkg::row_t               ram_wdata;

  always_comb begin
    if (num_rows_q == '0) begin
      rows_used = lgs_pkg::row_cnt_t'(1);
    end else if (int'(num_rows_q) > lgs_pkg::RowLimit) begin
      rows_used = lgs_pkg::row_cnt_t'(lgs_pkg::RowLimit);
    end else begin
      rows_used = lgs_pkg::row_cnt_t'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      cols_used = lgs_pkg::cfg_data_t'(1);
    end else if (int'(num_cols_q) > lgs_pkg::MaxCols) begin
      cols_used = lgs_pkg::cfg_data_t'(lgs_pkg::MaxCols);
    end else begin
      cols_used = num_cols_q;
    end
    if (int'(cols_used) >= lgs_pkg::RowW) begin
      col_mask = '1;
    end else begin
      col_mask = (lgs_pkg::row_t'(1) << cols_used) - lgs_pkg::row_t'(1);
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= lgs_pkg::cfg_data_t'(64);
      num_cols_q <= lgs_pkg::cfg_data_t'(64);
    end else if (cfg_i.valid) begin
      unique case (lgs_pkg::cfg_reg_e'(cfg_i.index))
        lgs_pkg::CfgNumRows: num_rows_q <= cfg_i.data;
        lgs_pkg::CfgNumCols: num_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  lgs_ram #(
    .Width (lgs_pkg::RowW),
    .Depth (lgs_pkg::MaxRows)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  lgs_row_calc u_calc (
    .above_i (above_q),
    .mid_i   (mid_q),
    .below_i (below),
    .mask_i  (col_mask),
    .next_o  (new_row)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign r_p1      = lgs_pkg::RowCntWp1'(r_q) + lgs_pkg::RowCntWp1'(1);
  assign r_p2      = lgs_pkg::RowCntWp1'(r_q) + lgs_pkg::RowCntWp1'(2);
  assign has_below = r_p1 < lgs_pkg::RowCntWp1'(rows_used);
  assign is_last   = r_p1 == lgs_pkg::RowCntWp1'(rows_used);
  assign below     = (has_below && rvalid_q) ? (rdata & col_mask) : '0;

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    above_d     = above_q;
    mid_d       = mid_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_idx_d   = out_idx_q;
    out_cells_d = out_cells_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = lgs_pkg::row_addr_t'(in_i.row_index);
    ram_wdata   = in_i.row_cells & col_mask;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (lgs_pkg::mode_e'(in_i.mode) == lgs_pkg::ModeStep) begin
            ram_re  = 1'b1;
            state_d = StPrime;
          end else if (int'(in_i.row_index) < lgs_pkg::MaxRows) begin
            ram_we            = 1'b1;
            valid_d[ram_waddr] = 1'b1;
          end
        end
      end
      StPrime: begin
        above_d   = '0;
        mid_d     = rvalid_q ? (rdata & col_mask) : '0;
        r_d       = '0;
        ram_re    = lgs_pkg::RowCntWp1'(1) < lgs_pkg::RowCntWp1'(rows_used);
        ram_raddr = lgs_pkg::row_addr_t'(1);
        state_d   = StCalc;
      end
      StCalc: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_idx_d          = lgs_pkg::IdxW'(r_q);
          out_cells_d        = new_row;
          out_last_d         = is_last;
          ram_we             = 1'b1;
          ram_waddr          = lgs_pkg::row_addr_t'(r_q);
          ram_wdata          = new_row;
          valid_d[ram_waddr] = 1'b1;
          above_d            = mid_q;
          mid_d              = below;
          r_d                = lgs_pkg::row_cnt_t'(r_p1);
          ram_re             = r_p2 < lgs_pkg::RowCntWp1'(rows_used);
          ram_raddr          = lgs_pkg::row_addr_t'(r_p2);
          if (is_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      r_q         <= '0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      if (ram_re) begin
        rvalid_q <= valid_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    above_q     <= above_d;
    mid_q       <= mid_d;
    out_idx_q   <= out_idx_d;
    out_cells_q <= out_cells_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_row_index = out_idx_q;
  assign out_o.out_row_cells = out_cells_q;
  assign out_o.last_row      = out_last_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("grid read and write hit the same row");

  a_calc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc) |-> (r_q < rows_used))
    else $error("row counter beyond rows in use");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_last_q && (state_q == StIdle))
      |-> (out_idx_q == lgs_pkg::IdxW'(rows_used - lgs_pkg::row_cnt_t'(1))))
    else $error("last row word carries wrong index");

endmodule

### design/lgs_ram.sv
// ----------------------------------------------------------------------------
// lgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lgs_row_calc.sv
// ----------------------------------------------------------------------------
// lgs_row_calc
// Next-generation cells of one row from the row and its two neighbors.
// ----------------------------------------------------------------------------
module lgs_row_calc (
  input  lgs_pkg::row_t above_i,
  input  lgs_pkg::row_t mid_i,
  input  lgs_pkg::row_t below_i,
  input  lgs_pkg::row_t mask_i,
  output lgs_pkg::row_t next_o
);

  lgs_pkg::row_t nb [8];
  lgs_pkg::row_t next_d;
  logic [3:0]    cnt;

  always_comb begin
    nb[0] = above_i << 1;
    nb[1] = above_i;
    nb[2] = above_i >> 1;
    nb[3] = mid_i << 1;
    nb[4] = mid_i >> 1;
    nb[5] = below_i << 1;
    nb[6] = below_i;
    nb[7] = below_i >> 1;
    next_d = '0;
    cnt    = '0;
    for (int c = 0; c < lgs_pkg::RowW; c++) begin
      cnt = 4'(nb[0][c]) + 4'(nb[1][c]) + 4'(nb[2][c]) + 4'(nb[3][c])
          + 4'(nb[4][c]) + 4'(nb[5][c]) + 4'(nb[6][c]) + 4'(nb[7][c]);
      next_d[c] = (cnt == 4'd3) || ((cnt == 4'd2) && mid_i[c]);
    end
  end

  assign next_o = next_d & mask_i;

endmodule
